// ===== rtl/ccm_pkg.sv =====
`timescale 1ns / 1ps
package ccm_pkg;

  localparam int CFG_W = 31;

  // configuration register indexes
  localparam logic [0:0] REG_RADIUS     = 1'b0;
  localparam logic [0:0] REG_ANGLE_MODE = 1'b1;

  localparam logic MODE_RADIANS = 1'b1;

  localparam logic [CFG_W-1:0] RADIUS_RESET = 31'd65536;

  // classified request handed from the front to the back
  typedef struct packed {
    logic [63:0] c2;
    logic [63:0] hrad;
    logic        clamped;
  } item_t;

  typedef struct packed {
    logic [23:0] central_angle;
    logic [39:0] arc_length;
    logic [47:0] sector_area;
    logic [47:0] segment_area;
    logic        ratio_clamped;
  } result_t;

endpackage

// ===== rtl/ccm_front.sv =====
`timescale 1ns / 1ps
module ccm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic signed [31:0]  first_x,
  input  logic signed [31:0]  first_y,
  input  logic signed [31:0]  second_x,
  input  logic signed [31:0]  second_y,
  input  logic [63:0]         d,
  output logic                out_valid,
  input  logic                out_ready,
  output ccm_pkg::item_t      out_item
);
  import ccm_pkg::*;

  logic        en;
  logic [2:0]  vld;
  logic [32:0] dx, dy, ax, ay;
  logic [31:0] ux, uy;
  logic [63:0] sx, sy;
  logic [64:0] c2s, diff;
  logic        clamped;
  item_t       item;

  assign en   = !vld[2] || out_ready;
  assign full = !en;

  assign dx = {second_x[31], second_x} - {first_x[31], first_x};
  assign dy = {second_y[31], second_y} - {first_y[31], first_y};
  assign ax = dx[32] ? (~dx + 33'd1) : dx;
  assign ay = dy[32] ? (~dy + 33'd1) : dy;

  // chord against 4 r^2, a carry out of the sum also clamps
  assign c2s     = {1'b0, sx} + {1'b0, sy};
  assign diff    = {1'b0, d} - {1'b0, c2s[63:0]};
  assign clamped = c2s[64] || diff[64];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], push};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux <= ax[31:0];
      uy <= ay[31:0];
      sx <= ux * ux;
      sy <= uy * uy;
      item.c2      <= clamped ? 64'd0 : c2s[63:0];
      item.hrad    <= clamped ? 64'd0 : diff[63:0];
      item.clamped <= clamped;
    end
  end

  assign out_valid = vld[2];
  assign out_item  = item;

endmodule

// ===== rtl/ccm_queue.sv =====
`timescale 1ns / 1ps
module ccm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ccm_pkg::item_t  in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output ccm_pkg::item_t  out_item
);
  import ccm_pkg::*;

  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);

  item_t            mem [QDEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [PTR_W:0]   count, count_next;
  logic             wr, rd;

  assign in_ready  = count != (PTR_W+1)'(QDEPTH);
  assign out_valid = count != '0;
  assign wr        = in_valid && in_ready;
  assign rd        = out_valid && out_ready;
  assign out_item  = mem[rptr];

  always_comb begin
    count_next = count;
    if (wr && !rd) begin
      count_next = count + 1'b1;
    end else if (rd && !wr) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= in_item;
    end
  end

endmodule

// ===== rtl/ccm_back.sv =====
`timescale 1ns / 1ps
module ccm_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ccm_pkg::item_t    in_item,
  input  logic [30:0]       radius,
  input  logic [61:0]       r2,
  input  logic              angle_mode,
  output logic              out_valid,
  input  logic              out_ready,
  output ccm_pkg::result_t  result
);
  import ccm_pkg::*;

  localparam int NSQ  = 32;
  localparam int NNM  = 6;
  localparam int NCD  = 30;
  localparam int NCV  = 3;
  localparam int NST  = (NSQ + 1) + (NNM + 1) + (NCD + 1) + 5 + NCV;

  localparam logic [31:0]        PI30      = 32'd3373259426;
  localparam logic [30:0]        HALF_PI30 = 31'd1686629713;
  localparam logic signed [32:0] HALF_Z    = 33'sd1686629713;
  localparam logic [94:0]        RND47     = 95'h400000000000;
  // floor(2^56 / pi30), never above the true reciprocal
  localparam logic [24:0]        RECIP_PI  = 25'd21361414;

  typedef struct packed {
    logic [63:0] nc, nh;
    logic [34:0] remc, remh;
    logic [31:0] rootc, rooth;
    logic        clamped;
  } sq_t;

  typedef struct packed {
    logic [40:0] m, x, y;
    logic [31:0] c, h;
    logic        czero, hzero, clamped;
  } nm_t;

  typedef struct packed {
    logic signed [45:0] x, y;
    logic signed [32:0] z;
    logic [31:0]        c, h;
    logic               czero, hzero, clamped;
  } cd_t;

  typedef struct packed {
    logic [18:0] rad;
    logic [39:0] arc;
    logic [47:0] sector, segment;
    logic        clamped;
  } cv_t;

  function automatic logic signed [32:0] atan_step(input int i);
    logic signed [32:0] a;
    case (i)
      0:       a = 33'sd843314857;
      1:       a = 33'sd497837829;
      2:       a = 33'sd263043837;
      3:       a = 33'sd133525159;
      4:       a = 33'sd67021687;
      5:       a = 33'sd33543516;
      6:       a = 33'sd16775851;
      7:       a = 33'sd8388437;
      8:       a = 33'sd4194283;
      9:       a = 33'sd2097149;
      default: a = 33'sd1 <<< (30 - i);
    endcase
    return a;
  endfunction

  // one result bit of a digit-by-digit square root
  function automatic logic [66:0] root_bit(input logic [34:0] rem, input logic [31:0] root,
                                           input logic [1:0] bits);
    logic [34:0] sr, trial;
    logic [34:0] rn;
    logic [31:0] qn;
    sr    = {rem[32:0], bits};
    trial = {1'b0, root, 2'b01};
    if (sr >= trial) begin
      rn = sr - trial;
      qn = {root[30:0], 1'b1};
    end else begin
      rn = sr;
      qn = {root[30:0], 1'b0};
    end
    return {rn, qn};
  endfunction

  function automatic sq_t sq_step(input sq_t s);
    sq_t o;
    o = s;
    {o.remc, o.rootc} = root_bit(s.remc, s.rootc, s.nc[63:62]);
    {o.remh, o.rooth} = root_bit(s.remh, s.rooth, s.nh[63:62]);
    o.nc = {s.nc[61:0], 2'b00};
    o.nh = {s.nh[61:0], 2'b00};
    return o;
  endfunction

  function automatic nm_t nm_step(input nm_t s, input int amt);
    nm_t o;
    o = s;
    if ((s.m >> (41 - amt)) == 41'd0) begin
      o.m = s.m << amt;
      o.x = s.x << amt;
      o.y = s.y << amt;
    end
    return o;
  endfunction

  function automatic cd_t cd_step(input cd_t s, input int i);
    cd_t                o;
    logic signed [45:0] xv, yv, xs, ys;
    o  = s;
    xv = s.x;
    yv = s.y;
    xs = xv >>> i;
    ys = yv >>> i;
    if (!yv[45]) begin
      o.x = xv + ys;
      o.y = yv - xs;
      o.z = s.z + atan_step(i);
    end else begin
      o.x = xv - ys;
      o.y = yv + xs;
      o.z = s.z - atan_step(i);
    end
    return o;
  endfunction

  logic           en, load;
  logic [NST-1:0] vld;

  sq_t sq [NSQ+1];
  nm_t nm [NNM+1];
  cd_t cd [NCD+1];
  cv_t cv [NCV];

  logic        [31:0] theta, theta_th, c_th, h_th;
  logic        [30:0] zc;
  logic signed [32:0] zv;
  logic               clamped_th;

  logic [56:0] degn_m1, degn_m2, degn_m3, degn_m4;
  logic [18:0] rad_m1, rad_m2, rad_m3, rad_m4;
  logic [62:0] arcp_m1;
  logic [63:0] plo_m1, ch_m1;
  logic [61:0] phi_m1;
  logic        cl_m1, cl_m2, cl_m3, cl_m4;
  logic [93:0] s_m2;
  logic [92:0] t_m2;
  logic [39:0] arc_m2, arc_m3, arc_m4;
  logic [94:0] diff, secsum, segsum;
  logic [93:0] diff_m3;
  logic        neg_m3;
  logic [47:0] sec_m3, sec_m4, seg_m4;

  logic [56:0] prod_c1, num_c1, num_c2, mul_c2;
  logic [34:0] rem_c;
  logic [23:0] qe_c2, qfix, q_c3;
  logic        ge1, ge2;

  assign en       = !vld[NST-1] || out_ready;
  assign in_ready = en;
  assign load     = en && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], load};
    end
  end

  // square roots of the chord and of 4 r^2 minus the chord
  always_ff @(posedge clk) begin
    if (en) begin
      sq[0].nc      <= in_item.c2;
      sq[0].nh      <= in_item.hrad;
      sq[0].remc    <= '0;
      sq[0].remh    <= '0;
      sq[0].rootc   <= '0;
      sq[0].rooth   <= '0;
      sq[0].clamped <= in_item.clamped;
      for (int k = 0; k < NSQ; k++) begin
        sq[k+1] <= sq_step(sq[k]);
      end
    end
  end

  // normalize so the larger leg has its top bit at 2^40
  always_ff @(posedge clk) begin
    if (en) begin
      nm[0].c       <= sq[NSQ].rootc;
      nm[0].h       <= sq[NSQ].rooth;
      nm[0].x       <= {9'd0, sq[NSQ].rooth};
      nm[0].y       <= {9'd0, sq[NSQ].rootc};
      nm[0].m       <= (sq[NSQ].rootc > sq[NSQ].rooth) ? {9'd0, sq[NSQ].rootc}
                                                       : {9'd0, sq[NSQ].rooth};
      nm[0].czero   <= sq[NSQ].rootc == 32'd0;
      nm[0].hzero   <= sq[NSQ].rooth == 32'd0;
      nm[0].clamped <= sq[NSQ].clamped;
      for (int j = 0; j < NNM; j++) begin
        nm[j+1] <= nm_step(nm[j], 32 >> j);
      end
    end
  end

  // vectoring rotations give the half angle
  always_ff @(posedge clk) begin
    if (en) begin
      cd[0].x       <= {5'd0, nm[NNM].x};
      cd[0].y       <= {5'd0, nm[NNM].y};
      cd[0].z       <= '0;
      cd[0].c       <= nm[NNM].c;
      cd[0].h       <= nm[NNM].h;
      cd[0].czero   <= nm[NNM].czero;
      cd[0].hzero   <= nm[NNM].hzero;
      cd[0].clamped <= nm[NNM].clamped;
      for (int i = 0; i < NCD; i++) begin
        cd[i+1] <= cd_step(cd[i], i);
      end
    end
  end

  always_comb begin
    zv = cd[NCD].z;
    if (zv[32]) begin
      zc = '0;
    end else if (zv > HALF_Z) begin
      zc = HALF_PI30;
    end else begin
      zc = zv[30:0];
    end
    if (cd[NCD].clamped) begin
      theta = PI30;
    end else if (cd[NCD].czero) begin
      theta = '0;
    end else if (cd[NCD].hzero) begin
      theta = PI30;
    end else begin
      theta = {zc, 1'b0};
    end
  end

  assign diff   = {1'b0, s_m2} - {2'b00, t_m2};
  assign secsum = {1'b0, s_m2} + RND47;
  assign segsum = {1'b0, diff_m3} + RND47;

  always_ff @(posedge clk) begin
    if (en) begin
      theta_th   <= theta;
      c_th       <= cd[NCD].c;
      h_th       <= cd[NCD].h;
      clamped_th <= cd[NCD].clamped;

      degn_m1 <= ((57'(theta_th) * 57'd45) << 18) + 57'(HALF_PI30);
      rad_m1  <= 19'(({1'b0, theta_th} + 33'd8192) >> 14);
      arcp_m1 <= radius * theta_th;
      plo_m1  <= r2[31:0] * theta_th;
      phi_m1  <= r2[61:32] * theta_th;
      ch_m1   <= c_th * h_th;
      cl_m1   <= clamped_th;

      s_m2    <= {phi_m1, 32'd0} + 94'(plo_m1);
      t_m2    <= {ch_m1, 29'd0};
      arc_m2  <= {6'd0, 34'((64'(arcp_m1) + 64'd536870912) >> 30)};
      degn_m2 <= degn_m1;
      rad_m2  <= rad_m1;
      cl_m2   <= cl_m1;

      diff_m3 <= diff[93:0];
      neg_m3  <= diff[94];
      sec_m3  <= secsum[94:47];
      arc_m3  <= arc_m2;
      degn_m3 <= degn_m2;
      rad_m3  <= rad_m2;
      cl_m3   <= cl_m2;

      // triangle larger than sector only through rounding of the roots
      seg_m4  <= neg_m3 ? 48'd0 : segsum[94:47];
      sec_m4  <= sec_m3;
      arc_m4  <= arc_m3;
      degn_m4 <= degn_m3;
      rad_m4  <= rad_m3;
      cl_m4   <= cl_m3;
    end
  end

  // estimate falls short of the quotient by at most two, fixed up from the remainder
  always_comb begin
    rem_c = 35'(num_c2 - mul_c2);
    ge2   = rem_c >= 35'({PI30, 1'b0});
    ge1   = rem_c >= 35'(PI30);
    qfix  = qe_c2 + 24'({ge2, ge1 && !ge2});
  end

  // radians to degrees: reciprocal multiply by 1/pi, then remainder correction
  always_ff @(posedge clk) begin
    if (en) begin
      prod_c1       <= degn_m4[55:24] * RECIP_PI;
      num_c1        <= degn_m4;
      cv[0].rad     <= rad_m4;
      cv[0].arc     <= arc_m4;
      cv[0].sector  <= sec_m4;
      cv[0].segment <= seg_m4;
      cv[0].clamped <= cl_m4;

      qe_c2  <= prod_c1[55:32];
      mul_c2 <= prod_c1[55:32] * PI30;
      num_c2 <= num_c1;

      q_c3 <= qfix;
      for (int k = 1; k < NCV; k++) begin
        cv[k] <= cv[k-1];
      end
    end
  end

  assign out_valid = vld[NST-1];

  always_comb begin
    result.central_angle = (angle_mode == MODE_RADIANS) ? {5'd0, cv[NCV-1].rad} : q_c3;
    result.arc_length    = cv[NCV-1].arc;
    result.sector_area   = cv[NCV-1].sector;
    result.segment_area  = cv[NCV-1].segment;
    result.ratio_clamped = cv[NCV-1].clamped;
  end

endmodule

// ===== rtl/circle_chord_measures_core.sv =====
`timescale 1ns / 1ps
// channel   ports                                         handshake
// --------  --------------------------------------------  ------------------------
// input     first_x first_y second_x second_y              push / full
// result    central_angle arc_length sector_area           empty / pop
//           segment_area ratio_clamped
// config    cfg_index cfg_data                             cfg_write, no wait
//
// one request per cycle sustained while results are popped; a request passes the
// front, the queue and the back, whose depth is set by the 32-step square roots,
// 30 rotation stages and a 3-stage reciprocal conversion to degrees.
// rst is synchronous; it empties the front, queue and back and loads radius 1.0.
// a result waiting on pop stalls the back only; the front and queue keep taking
// requests until the queue fills.
module circle_chord_measures_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic signed [31:0]         first_x,
  input  logic signed [31:0]         first_y,
  input  logic signed [31:0]         second_x,
  input  logic signed [31:0]         second_y,
  output logic                       empty,
  input  logic                       pop,
  output logic [23:0]                central_angle,
  output logic [39:0]                arc_length,
  output logic [47:0]                sector_area,
  output logic [47:0]                segment_area,
  output logic                       ratio_clamped,
  input  logic                       cfg_write,
  input  logic [0:0]                 cfg_index,
  input  logic [ccm_pkg::CFG_W-1:0]  cfg_data
);
  import ccm_pkg::*;

  logic [CFG_W-1:0] radius;
  logic             angle_mode;
  logic [61:0]      r2;
  logic [63:0]      d;

  logic    f_valid, q_ready, q_valid, b_ready, b_valid;
  item_t   f_item, q_item;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius     <= RADIUS_RESET;
      angle_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RADIUS:     radius     <= cfg_data;
        REG_ANGLE_MODE: angle_mode <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r2 <= radius * radius;
  end

  assign d = {r2, 2'b00};

  ccm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .first_x   (first_x),
    .first_y   (first_y),
    .second_x  (second_x),
    .second_y  (second_y),
    .d         (d),
    .out_valid (f_valid),
    .out_ready (q_ready),
    .out_item  (f_item)
  );

  ccm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (q_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (b_ready),
    .out_item  (q_item)
  );

  ccm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_valid),
    .in_ready   (b_ready),
    .in_item    (q_item),
    .radius     (radius),
    .r2         (r2),
    .angle_mode (angle_mode),
    .out_valid  (b_valid),
    .out_ready  (pop),
    .result     (res)
  );

  assign empty         = !b_valid;
  assign central_angle = res.central_angle;
  assign arc_length    = res.arc_length;
  assign sector_area   = res.sector_area;
  assign segment_area  = res.segment_area;
  assign ratio_clamped = res.ratio_clamped;

endmodule

// ===== rtl/ccm_checker.sv =====
`timescale 1ns / 1ps
module ccm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       full,
  input logic                       empty,
  input logic                       pop,
  input logic [23:0]                central_angle,
  input logic [47:0]                sector_area,
  input logic [47:0]                segment_area,
  input logic                       ratio_clamped
);

  // reset leaves nothing in flight and room for a request
  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not cleared by reset");

  // a clamped ratio has no triangle, so the segment is the whole sector
  a_clamp_segment: assert property (@(posedge clk) disable iff (rst)
    !empty && ratio_clamped |-> segment_area == sector_area)
    else $error("clamped segment differs from sector");

  a_segment_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> segment_area <= sector_area)
    else $error("segment larger than sector");

  a_angle_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> central_angle <= 24'd11796480)
    else $error("angle beyond half turn");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(central_angle) && $stable(sector_area))
    else $error("waiting result changed");

endmodule

bind circle_chord_measures_core ccm_checker u_ccm_checker (.*);

// ===== tb/circle_chord_measures_core_test.sv =====
`timescale 1ns / 1ps
module circle_chord_measures_core_test;
  import ccm_pkg::*;

  localparam bit [63:0] PI_Q30 = 64'd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam int DRAIN_CYCLES = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic signed [31:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
  logic empty;
  logic pop = 1'b0;
  logic [23:0] central_angle;
  logic [39:0] arc_length;
  logic [47:0] sector_area, segment_area;
  logic ratio_clamped;
  logic cfg_write = 1'b0;
  logic [0:0] cfg_index = REG_RADIUS;
  logic [CFG_W-1:0] cfg_data = '0;

  // predictor copy of the registers
  bit [63:0] radius_q = 64'd65536;
  bit angle_mode_q = 1'b0;

  result_t pending_measures[$];
  int mismatch_count = 0;
  bit hold_pop = 1'b0;
  int pop_stall = 0;

  circle_chord_measures_core u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .first_x(first_x), .first_y(first_y), .second_x(second_x), .second_y(second_y),
    .empty(empty), .pop(pop), .central_angle(central_angle), .arc_length(arc_length),
    .sector_area(sector_area), .segment_area(segment_area),
    .ratio_clamped(ratio_clamped), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit [63:0] floor_sqrt(bit [63:0] n);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint atan_entry(int i);
    case (i)
      0: return 843314857;
      1: return 497837829;
      2: return 263043837;
      3: return 133525159;
      4: return 67021687;
      5: return 33543516;
      6: return 16775851;
      7: return 8388437;
      8: return 4194283;
      9: return 2097149;
      default: return longint'(1) << (30 - i);
    endcase
  endfunction

  // cordic vectoring, half angle atan2(c, h) in 2^-30 rad
  function automatic longint half_angle_q30(bit [63:0] c, bit [63:0] h);
    longint x, y, z, xs, ys;
    bit [63:0] m;
    x = h;
    y = c;
    z = 0;
    m = (c > h) ? c : h;
    if (c == 0) return 0;
    if (h == 0) return HALF_PI_Q30;
    while (m < (64'd1 << 40)) begin
      m <<= 1;
      x *= 2;
      y *= 2;
    end
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_entry(i);
      end else begin
        x -= ys; y += xs; z -= atan_entry(i);
      end
    end
    if (z < 0) z = 0;
    if (z > HALF_PI_Q30) z = HALF_PI_Q30;
    return z;
  endfunction

  function automatic bit [127:0] round_q47(bit [127:0] a);
    return (a + (128'd1 << 46)) >> 47;
  endfunction

  function automatic result_t chord_measures(logic signed [31:0] ax, logic signed [31:0] ay,
                                             logic signed [31:0] bx, logic signed [31:0] by);
    longint dx, dy;
    bit [63:0] ux, uy, c2, r2, d, c, h, theta, angle, ch;
    bit [64:0] sum;
    bit clamped;
    bit [127:0] s, t, diff;
    result_t r;
    dx = longint'(bx) - longint'(ax);
    dy = longint'(by) - longint'(ay);
    ux = (dx < 0) ? -dx : dx;
    uy = (dy < 0) ? -dy : dy;
    sum = {1'b0, ux * ux} + {1'b0, uy * uy};
    c2 = sum[63:0];
    r2 = radius_q * radius_q;
    d = r2 << 2;
    c = 0;
    h = 0;
    clamped = sum[64] || (c2 > d);
    if (clamped) begin
      theta = PI_Q30;
    end else begin
      c = floor_sqrt(c2);
      h = floor_sqrt(d - c2);
      theta = 64'(half_angle_q30(c, h)) * 2;
    end
    if (angle_mode_q == MODE_RADIANS) angle = (theta + 64'd8192) >> 14;
    else angle = (theta * 64'd180 * 64'd65536 + PI_Q30 / 2) / PI_Q30;
    s = 128'(r2) * 128'(theta);
    ch = c * h;
    t = 128'(ch) << 29;
    r.central_angle = angle[23:0];
    r.arc_length = 40'((radius_q * theta + (64'd1 << 29)) >> 30);
    r.sector_area = 48'(round_q47(s));
    if (s < t) r.segment_area = '0;
    else begin
      diff = s - t;
      r.segment_area = 48'(round_q47(diff));
    end
    r.ratio_clamped = clamped;
    return r;
  endfunction

  function automatic int random_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // result side: check accepted results and pace pop
  always @(posedge clk) begin
    result_t exp_r;
    bit next_pop;
    if (!rst && pop && !empty) begin
      if (pending_measures.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        exp_r = pending_measures.pop_front();
        if (exp_r.central_angle !== central_angle || exp_r.arc_length !== arc_length ||
            exp_r.sector_area !== sector_area || exp_r.segment_area !== segment_area ||
            exp_r.ratio_clamped !== ratio_clamped) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: exp ang %0d arc %0d sec %0d seg %0d clamp %0b",
                     exp_r.central_angle, exp_r.arc_length, exp_r.sector_area,
                     exp_r.segment_area, exp_r.ratio_clamped);
            $display("          got ang %0d arc %0d sec %0d seg %0d clamp %0b",
                     central_angle, arc_length, sector_area, segment_area, ratio_clamped);
          end
        end
      end
    end
    if (hold_pop) next_pop = 1'b0;
    else if (pop_stall > 0) begin
      pop_stall--;
      next_pop = 1'b0;
    end else begin
      next_pop = 1'b1;
      if ($urandom_range(0, 5) == 0) pop_stall = random_gap();
    end
    pop <= next_pop;
  end

  task automatic send_request(logic signed [31:0] ax, logic signed [31:0] ay,
                              logic signed [31:0] bx, logic signed [31:0] by, bit no_gap = 0);
    int gap;
    push <= 1'b1;
    first_x <= ax;
    first_y <= ay;
    second_x <= bx;
    second_y <= by;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_measures.insert(pending_measures.size(), chord_measures(ax, ay, bx, by));
    gap = no_gap ? 0 : ($urandom_range(0, 2) == 0 ? random_gap() : 0);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending_measures.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [0:0] idx, bit [CFG_W-1:0] value);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_RADIUS) radius_q = 64'(value);
    else angle_mode_q = value[0];
  endtask

  function automatic int to_coord(real v);
    real f;
    f = $floor(v + 0.5);
    if (f > 2147483647.0) f = 2147483647.0;
    if (f < -2147483648.0) f = -2147483648.0;
    return int'(longint'(f));
  endfunction

  // random pair on the circle, sometimes nudged a few lsb off it
  task automatic send_circle_pair(bit no_gap = 0);
    real a1, a2, rr;
    int nudge;
    rr = real'(radius_q);
    a1 = ($urandom() / 4294967296.0) * 6.283185307179586;
    case ($urandom_range(0, 4))
      0: a2 = a1 + 3.141592653589793;
      1: a2 = a1 + ($urandom_range(0, 1000) / 1.0e6);
      default: a2 = ($urandom() / 4294967296.0) * 6.283185307179586;
    endcase
    nudge = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) - 2 : 0;
    send_request(to_coord(rr * $cos(a1)), to_coord(rr * $sin(a1)),
                 to_coord(rr * $cos(a2)) + nudge, to_coord(rr * $sin(a2)), no_gap);
  endtask

  task automatic test_reset_defaults();
    send_request(32'sd65536, 0, 0, 32'sd65536);
    send_request(32'sd65536, 0, -32'sd65536, 0);
    send_request(0, 0, 0, 0);
  endtask

  task automatic test_directed();
    for (int m = 0; m < 2; m++) begin
      write_config(REG_ANGLE_MODE, CFG_W'(m));
      for (int i = 0; i < 3; i++) begin
        write_config(REG_RADIUS, (i == 0) ? 31'd1 : (i == 1) ? 31'h7fffffff : 31'd200000);
        send_request(32'sd5, -32'sd7, 32'sd5, -32'sd7);
        send_request(int'(radius_q), 0, -int'(radius_q), 0);
        send_request(0, int'(radius_q), int'(radius_q), 0);
        send_request(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
        send_request(32'h80000000, 0, 32'h7fffffff, 0);
        send_request(int'(radius_q), 0, int'(radius_q), 1);
        send_circle_pair();
      end
    end
  endtask

  task automatic test_random_phases(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      case (p % 5)
        0: write_config(REG_RADIUS, CFG_W'($urandom_range(4096, 1 << 22)));
        1: write_config(REG_RADIUS, CFG_W'($urandom_range(1, 31'h7fffffff)));
        2: write_config(REG_RADIUS, 31'h7fffffff);
        3: write_config(REG_RADIUS, CFG_W'($urandom_range(1, 64)));
        default: write_config(REG_RADIUS, 31'd65536);
      endcase
      write_config(REG_ANGLE_MODE, CFG_W'($urandom_range(0, 1)));
      for (int n = 0; n < per_phase; n++) begin
        case ($urandom_range(0, 9))
          0: send_request($urandom(), $urandom(), $urandom(), $urandom());
          1: send_request(int'(radius_q), -32'sd3, int'(radius_q), -32'sd3);
          default: send_circle_pair();
        endcase
      end
    end
  endtask

  // hold results back long enough that the block fills and stalls requests
  task automatic test_backpressure();
    fork
      begin
        hold_pop = 1'b1;
        repeat (600) @(posedge clk);
        hold_pop = 1'b0;
      end
      for (int n = 0; n < 300; n++) send_circle_pair(1'b1);
    join
  endtask

  task automatic test_drain_pause();
    wait_idle();
    for (int n = 0; n < 40; n++) send_circle_pair(1'b1);
    wait_idle();
    for (int n = 0; n < 40; n++) send_circle_pair();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_backpressure();
    test_drain_pause();
    test_random_phases(10, 120);
    wait_idle();
    if (mismatch_count == 0 && pending_measures.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== circle_chord_measures_core.f =====
rtl/ccm_pkg.sv
rtl/ccm_front.sv
rtl/ccm_queue.sv
rtl/ccm_back.sv
rtl/circle_chord_measures_core.sv
rtl/ccm_checker.sv
tb/circle_chord_measures_core_test.sv
